// ===== hdl/sali_pkg.sv =====
// package for the six-axis linear interpolator: item types and constants
// no dependencies
package sali_pkg;

    localparam int NAXES = 6;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] target_lin_1;
        logic [7:0] target_rot_1;
        logic [7:0] target_lin_2;
        logic [7:0] target_rot_2;
        logic [7:0] target_lin_3;
        logic [7:0] target_rot_3;
        logic [7:0] step_delay;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pos_lin_1;
        logic [7:0] pos_rot_1;
        logic [7:0] pos_lin_2;
        logic [7:0] pos_rot_2;
        logic [7:0] pos_lin_3;
        logic [7:0] pos_rot_3;
        logic       last_step;
        logic       status;
    } t_out_item;

endpackage

// ===== hdl/sali_fifo.sv =====
// short item queue between the front and the back part
// depends on sali_pkg
module sali_fifo import sali_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr,
    input  t_in_item i_data,
    output logic     o_full,
    input  logic     i_rd,
    output logic     o_empty,
    output t_in_item o_data
);
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== hdl/sali_engine.sv =====
// back part: move setup with a serial divider, step timing and output register
// depends on sali_pkg
module sali_engine import sali_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_in_item  i_item,
    output logic      o_rd,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);
    localparam int AW = 8 + FRAC_BITS + 1;   // signed accumulator width
    localparam int NW = 8 + FRAC_BITS;       // dividend width
    localparam int CW = $clog2(NW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SPAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0]          r_st;
    logic [7:0]          r_pos [NAXES];
    logic signed [AW-1:0] r_acc [NAXES];
    logic signed [AW-1:0] r_inc [NAXES];
    logic [7:0]          r_tgt [NAXES];
    logic [7:0]          r_steps, r_ticks, r_delay, r_span;
    logic                r_moving;
    logic [2:0]          r_ax;
    logic [CW-1:0]       r_bit;
    logic [NW-1:0]       r_quo;
    logic [8:0]          r_rem;
    logic                r_valid;
    t_out_item           r_out;
    logic                r_last;

    logic [7:0] tgt [NAXES];
    logic [7:0] mag [NAXES];
    logic [7:0] span;
    logic [NW-1:0] num;
    logic [8:0] trial;
    logic [7:0] rnd [NAXES];
    logic       out_free;

    assign out_free = !r_valid || !i_stall;

    always_comb begin
        tgt[0] = i_item.target_lin_1;
        tgt[1] = i_item.target_rot_1;
        tgt[2] = i_item.target_lin_2;
        tgt[3] = i_item.target_rot_2;
        tgt[4] = i_item.target_lin_3;
        tgt[5] = i_item.target_rot_3;
    end

    // absolute differences and their maximum
    always_comb begin
        span = '0;
        for (int i = 0; i < NAXES; i++) begin
            mag[i] = (r_tgt[i] >= r_pos[i]) ? r_tgt[i] - r_pos[i] : r_pos[i] - r_tgt[i];
            if (mag[i] > span) begin
                span = mag[i];
            end
        end
    end

    // rounding of accumulators, halves up, clamped
    always_comb begin
        for (int i = 0; i < NAXES; i++) begin
            logic signed [AW:0] s;
            s = {r_acc[i][AW-1], r_acc[i]} + (AW+1)'(1 << (FRAC_BITS - 1));
            if (r_acc[i] <= 0) begin
                rnd[i] = '0;
            end else if (s[AW:FRAC_BITS] > 255) begin
                rnd[i] = 8'hff;
            end else begin
                rnd[i] = s[FRAC_BITS+7:FRAC_BITS];
            end
        end
    end

    // restoring division, one quotient bit a cycle
    assign num   = {mag[r_ax], {FRAC_BITS{1'b0}}};
    assign trial = {r_rem[7:0], num[r_bit[CW-1:0] - CW'(1)]};

    assign o_rd = (r_st == ST_IDLE) && !i_empty && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_moving <= 1'b0;
            r_valid  <= 1'b0;
            r_steps  <= '0;
            r_ticks  <= '0;
            r_delay  <= '0;
            for (int i = 0; i < NAXES; i++) begin
                r_pos[i] <= '0;
                r_acc[i] <= '0;
                r_inc[i] <= '0;
            end
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (o_rd) begin
                        if (i_item.kind == KIND_MOVE) begin
                            if (r_moving) begin
                                r_out.pos_lin_1 <= rnd[0];
                                r_out.pos_rot_1 <= rnd[1];
                                r_out.pos_lin_2 <= rnd[2];
                                r_out.pos_rot_2 <= rnd[3];
                                r_out.pos_lin_3 <= rnd[4];
                                r_out.pos_rot_3 <= rnd[5];
                                r_out.last_step <= 1'b0;
                                r_out.status    <= 1'b1;
                                r_valid <= 1'b1;
                            end else begin
                                for (int i = 0; i < NAXES; i++) begin
                                    r_tgt[i] <= tgt[i];
                                end
                                r_delay <= (i_item.step_delay == 8'd0) ? 8'd1
                                           : i_item.step_delay;
                                r_st <= ST_SPAN;
                            end
                        end else if (r_moving) begin
                            if (r_ticks + 8'd1 >= r_delay) begin
                                if (r_steps == 8'd0) begin
                                    r_moving <= 1'b0;
                                    r_ticks  <= '0;
                                end else begin
                                    r_st <= ST_EMIT;
                                end
                            end else begin
                                r_ticks <= r_ticks + 8'd1;
                            end
                        end
                    end
                end
                ST_SPAN: begin
                    if (span == 8'd0) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_span <= span;
                        r_ax   <= '0;
                        r_bit  <= CW'(NW);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_st   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == '0) begin
                        r_inc[r_ax] <= (r_tgt[r_ax] < r_pos[r_ax])
                                       ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
                        r_acc[r_ax] <= $signed(AW'({r_pos[r_ax], {FRAC_BITS{1'b0}}}));
                        r_pos[r_ax] <= r_tgt[r_ax];
                        r_bit <= CW'(NW);
                        r_rem <= '0;
                        r_quo <= '0;
                        if (r_ax == 3'(NAXES - 1)) begin
                            r_steps  <= r_span;
                            r_moving <= 1'b1;
                            r_st     <= ST_EMIT;
                        end else begin
                            r_ax <= r_ax + 3'd1;
                        end
                    end else begin
                        r_bit <= r_bit - CW'(1);
                        if (trial >= {1'b0, r_span}) begin
                            r_rem <= trial - {1'b0, r_span};
                            r_quo <= {r_quo[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= trial;
                            r_quo <= {r_quo[NW-2:0], 1'b0};
                        end
                    end
                end
                ST_EMIT: begin
                    // step accumulators, or land exactly on the targets
                    r_steps <= r_steps - 8'd1;
                    r_ticks <= '0;
                    for (int i = 0; i < NAXES; i++) begin
                        if (r_steps == 8'd1) begin
                            r_acc[i] <= $signed(AW'({r_pos[i], {FRAC_BITS{1'b0}}}));
                        end else begin
                            r_acc[i] <= r_acc[i] + r_inc[i];
                        end
                    end
                    r_last <= (r_steps == 8'd1);
                    r_st   <= ST_LOAD;
                end
                ST_LOAD: begin
                    // load output register from the updated accumulators
                    r_out.pos_lin_1 <= rnd[0];
                    r_out.pos_rot_1 <= rnd[1];
                    r_out.pos_lin_2 <= rnd[2];
                    r_out.pos_rot_2 <= rnd[3];
                    r_out.pos_lin_3 <= rnd[4];
                    r_out.pos_rot_3 <= rnd[5];
                    r_out.last_step <= r_last;
                    r_out.status    <= 1'b0;
                    r_valid <= 1'b1;
                    r_st    <= ST_IDLE;
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;
endmodule

// ===== hdl/six_axis_linear_interpolator.sv =====
// Six-axis linear interpolator, top level: item queue and interpolation engine.
// Depends on sali_pkg, sali_fifo, sali_engine.
//
// A move item is set up by the serial divider, which works one quotient bit a
// cycle for each axis in turn; a tick that emits a step passes through the emit
// and load states. A two-entry queue takes items while the engine is busy. Each
// result item is held in an output register until taken.
module six_axis_linear_interpolator import sali_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    logic     full, empty, rd;
    t_in_item q_item;

    // front part: queue the incoming items
    sali_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_valid && !full),
        .i_data  (i_item),
        .o_full  (full),
        .i_rd    (rd),
        .o_empty (empty),
        .o_data  (q_item)
    );

    assign o_stall = full;

    // back part: carry out moves and ticks
    sali_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (q_item),
        .o_rd    (rd),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

`ifndef SYNTH
    // the engine never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd |-> !empty) else $error("pop of empty queue");
    // a stalled result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed under stall");
    // a full queue stalls the input
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> o_stall) else $error("queue overflow");
`endif
endmodule

// ===== tb/sv/testbench.sv =====
// testbench for six_axis_linear_interpolator: random and directed moves and ticks
// depends on sali_pkg and the interpolator rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sali_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 400;
    localparam int IN_W = $bits(t_in_item);
    localparam int N_ITEMS = 1850;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b1;
    t_out_item o_item;

    six_axis_linear_interpolator #(.FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always #5 i_clk = ~i_clk;

    // interpolator state mirrored for prediction
    logic [7:0]         axis_pos [6];
    logic signed [40:0] axis_acc [6];
    logic signed [40:0] axis_inc [6];
    logic [7:0]         steps_left;
    logic [7:0]         tick_cnt;
    logic [7:0]         step_gap;
    logic               busy;

    t_in_item  pending_items[$];
    t_out_item expected_positions[$];
    int errors = 0;
    int n_moves = 0, n_ticks = 0, n_steps = 0, n_rejects = 0;
    int cycles = 0;
    bit stim_done = 0;
    int hold_off = 0;
    logic long_done = 1'b0;

    function automatic logic [7:0] round_pos(logic signed [40:0] acc);
        logic signed [40:0] v;
        if (acc <= 0) return 8'd0;
        v = (acc + (41'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_out_item pack_positions(logic last, logic stat);
        t_out_item r;
        r.pos_lin_1 = round_pos(axis_acc[0]);
        r.pos_rot_1 = round_pos(axis_acc[1]);
        r.pos_lin_2 = round_pos(axis_acc[2]);
        r.pos_rot_2 = round_pos(axis_acc[3]);
        r.pos_lin_3 = round_pos(axis_acc[4]);
        r.pos_rot_3 = round_pos(axis_acc[5]);
        r.last_step = last;
        r.status = stat;
        return r;
    endfunction

    task automatic advance_step();
        logic last;
        last = 1'b0;
        if (steps_left > 0) steps_left--;
        if (steps_left == 0) begin
            for (int i = 0; i < 6; i++) axis_acc[i] = $signed({33'd0, axis_pos[i]}) <<< FRAC;
            last = 1'b1;
        end else begin
            for (int i = 0; i < 6; i++) axis_acc[i] += axis_inc[i];
        end
        tick_cnt = 0;
        expected_positions.push_back(pack_positions(last, 1'b0));
        n_steps++;
    endtask

    // predict results of one accepted item
    task automatic predict_item(t_in_item it);
        logic [7:0] tgt [6];
        int diff [6];
        int span, mag;
        longint q;
        tgt = '{it.target_lin_1, it.target_rot_1, it.target_lin_2,
                it.target_rot_2, it.target_lin_3, it.target_rot_3};
        span = 0;
        if (it.kind == KIND_MOVE) begin
            n_moves++;
            if (busy) begin
                expected_positions.push_back(pack_positions(1'b0, 1'b1));
                n_rejects++;
                return;
            end
            for (int i = 0; i < 6; i++) begin
                diff[i] = int'(tgt[i]) - int'(axis_pos[i]);
                mag = diff[i] < 0 ? -diff[i] : diff[i];
                if (mag > span) span = mag;
            end
            if (span == 0) return;
            for (int i = 0; i < 6; i++) begin
                mag = diff[i] < 0 ? -diff[i] : diff[i];
                q = (longint'(mag) << FRAC) / span;
                axis_inc[i] = diff[i] < 0 ? 41'(-q) : 41'(q);
                axis_acc[i] = $signed({33'd0, axis_pos[i]}) <<< FRAC;
                axis_pos[i] = tgt[i];
            end
            step_gap = (it.step_delay == 0) ? 8'd1 : it.step_delay;
            steps_left = span[7:0];
            busy = 1'b1;
            advance_step();
        end else begin
            n_ticks++;
            if (!busy) return;
            tick_cnt++;
            if (tick_cnt < step_gap) return;
            if (steps_left == 0) begin
                busy = 1'b0;
                tick_cnt = 0;
                return;
            end
            advance_step();
        end
    endtask

    function automatic t_in_item make_move(logic [7:0] a, b, c, d, e, f, logic [7:0] dly);
        t_in_item it;
        it = '{KIND_MOVE, a, b, c, d, e, f, dly};
        return it;
    endfunction

    function automatic t_in_item make_tick();
        t_in_item it;
        it = IN_W'({$urandom, $urandom});
        it.kind = KIND_TICK;
        return it;
    endfunction

    // random gap: mostly short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus
    initial begin
        t_in_item it;
        int small_move, dly, nt;
        // directed: extremes, zero delay, zero-difference, reject while busy
        pending_items.push_back(make_move(255, 255, 255, 255, 255, 255, 0));
        pending_items.push_back(make_move(0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++) pending_items.push_back(make_tick());
        pending_items.push_back(make_move(0, 0, 0, 0, 0, 0, 3));
        pending_items.push_back(make_move(3, 0, 1, 2, 0, 3, 2));
        pending_items.push_back(make_move(9, 9, 9, 9, 9, 9, 1));
        for (int i = 0; i < 10; i++) pending_items.push_back(make_tick());
        pending_items.push_back(make_move(0, 5, 2, 0, 1, 4, 255));
        pending_items.push_back(make_move(0, 5, 2, 0, 1, 4, 0));
        for (int i = 0; i < 4; i++) pending_items.push_back(make_tick());
        // random well-formed moves, each followed by a run of ticks, plus noise
        while (pending_items.size() < N_ITEMS) begin
            small_move = $urandom_range(0, 99) < 85;
            dly = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            it = IN_W'({$urandom, $urandom});
            it.kind = KIND_MOVE;
            it.step_delay = 8'(dly);
            if (small_move) begin
                it.target_lin_1 = it.target_lin_1 & 8'h0f | ($urandom_range(0, 1) ? 8'hf0 : 8'h00);
                it.target_rot_1 = it.target_rot_1 & 8'h0f | ($urandom_range(0, 1) ? 8'hf0 : 8'h00);
                it.target_lin_2 = it.target_lin_2 & 8'h0f;
                it.target_rot_2 = it.target_rot_2 & 8'h0f;
                it.target_lin_3 = it.target_lin_3 & 8'h0f;
                it.target_rot_3 = it.target_rot_3 & 8'h0f;
            end
            pending_items.push_back(it);
            nt = (dly == 0 ? 1 : dly) * 20;
            if (nt > 300 || $urandom_range(0, 4) == 0) nt = $urandom_range(0, 300);
            for (int i = 0; i < nt && pending_items.size() < N_ITEMS; i++) begin
                if ($urandom_range(0, 49) == 0) pending_items.push_back(it);
                else pending_items.push_back(make_tick());
            end
        end
    end

    // reset, then cycle limit and end
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d items pending", pending_items.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    int send_gap = 0;
    logic in_fire;
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_valid && !o_stall;
        // accept at rising edge: predict and check
        if (i_rst_n && i_valid && !o_stall) predict_item(i_item);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_positions.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_item);
            end else if (o_item !== expected_positions[0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p got %p", expected_positions[0], o_item);
                void'(expected_positions.pop_front());
            end else begin
                void'(expected_positions.pop_front());
            end
        end
    end

    // driver: offer the next item at falling edges
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire || !i_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_item <= pending_items.pop_front();
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor side stall: random, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if (n_moves >= 10 && !long_done) begin
            hold_off <= 3000;
            long_done <= 1'b1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 20) begin
            hold_off <= pick_gap();
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // end of run
    initial begin
        for (int i = 0; i < 6; i++) begin
            axis_pos[i] = 0;
            axis_acc[i] = 0;
            axis_inc[i] = 0;
        end
        steps_left = 0;
        tick_cnt = 0;
        step_gap = 0;
        busy = 0;
        wait (i_rst_n);
        repeat (5) @(posedge i_clk);
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_positions.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d moves (%0d rejected), %0d ticks, %0d steps checked",
                 n_moves, n_rejects, n_ticks, n_steps);
        if (errors == 0 && expected_positions.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_positions.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
